// ===== rtl/core/ppt_pkg.sv =====
// shared types, constants and codes of the paired page tlb
package ppt_pkg;

  localparam int unsigned ENTRIES_DEF          = 32;
  localparam int unsigned PAGE_OFFSET_BITS_DEF = 12;

  localparam int unsigned VA_W   = 32;
  localparam int unsigned PN_W   = 20;
  localparam int unsigned FN_W   = 20;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned CIDX_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_TRANSLATE  = 2'd0,
    KIND_INSERT     = 2'd1,
    KIND_INVALIDATE = 2'd2
  } kind_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_ADDR_ERR  = 3'd1,
    ST_MISS      = 3'd2,
    ST_INVALID   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_KERNEL     = 2'd0,
    MODE_SUPERVISOR = 2'd1,
    MODE_USER       = 2'd2
  } mode_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_KERNEL_MAPPED     = 2'd0,
    CFG_SUPERVISOR_MAPPED = 2'd1,
    CFG_KERNEL_UNCACHED   = 2'd2,
    CFG_KERNEL_UNMAPPED   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] k_map_mask;
    logic [CFG_W-1:0] s_map_mask;
    logic [CFG_W-1:0] k_uncached_mask;
    logic [CFG_W-1:0] k_cached_mask;
  } cfg_t;

  // segment decision taken before any table walk
  typedef struct packed {
    logic            done;
    logic [ST_W-1:0] status;
  } seg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VA_W-1:0]   va;
    logic [PN_W-1:0]   page;
    logic [FN_W-1:0]   frame;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [VA_W-1:0] pa;
  } res_t;

  typedef struct packed {
    logic [PN_W-1:0] tag;
    logic [FN_W-1:0] even_frame;
    logic [FN_W-1:0] odd_frame;
    logic            even_valid;
    logic            odd_valid;
  } entry_t;

endpackage

// ===== rtl/core/ppt_ram.sv =====
// generic single write, single read ram with registered read data
module ppt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ppt_seg.sv =====
// segment decode of a virtual address against the four mask registers
module ppt_seg (
  input  logic [ppt_pkg::VA_W-1:0]   va_i,
  input  logic [ppt_pkg::MODE_W-1:0] mode_i,
  input  ppt_pkg::cfg_t              cfg_i,
  output ppt_pkg::seg_t              seg_o
);
  import ppt_pkg::*;

  logic km_hit, sm_hit, ku_hit, kc_hit;

  assign km_hit = |(va_i & cfg_i.k_map_mask);
  assign sm_hit = |(va_i & cfg_i.s_map_mask);
  assign ku_hit = |(va_i & cfg_i.k_uncached_mask);
  assign kc_hit = |(va_i & cfg_i.k_cached_mask);

  // first matching mask wins; mapped segments in the right mode report a miss
  always_comb begin
    seg_o.done   = km_hit | sm_hit | ku_hit | kc_hit;
    seg_o.status = ST_ADDR_ERR;
    if (km_hit) begin
      seg_o.status = (mode_i == MODE_KERNEL) ? ST_MISS : ST_ADDR_ERR;
    end else if (sm_hit) begin
      seg_o.status = (mode_i == MODE_SUPERVISOR) ? ST_MISS : ST_ADDR_ERR;
    end
  end

endmodule

// ===== rtl/core/ppt_engine.sv =====
// table walk engine: entry memory, per-entry written bits and the walk sequencer
module ppt_engine #(
  parameter int unsigned ENTRIES          = ppt_pkg::ENTRIES_DEF,
  parameter int unsigned PAGE_OFFSET_BITS = ppt_pkg::PAGE_OFFSET_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  ppt_pkg::req_t req_i,
  input  ppt_pkg::seg_t seg_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output ppt_pkg::res_t res_o
);
  import ppt_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned EW = $bits(entry_t);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_e;

  state_e                      state_q, state_d;
  logic [KIND_W-1:0]           kind_q, kind_d;
  logic [PN_W-1:0]             tag_q, tag_d;
  logic                        odd_q, odd_d;
  logic [FN_W-1:0]             frame_q, frame_d;
  logic [PAGE_OFFSET_BITS-1:0] off_q, off_d;
  logic [CW-1:0]               iss_q, iss_d;
  logic                        rvalid_q, rvalid_d;
  logic [AW-1:0]               raddr_q, raddr_d;
  logic                        spare_q, spare_d;
  logic [AW-1:0]               spare_idx_q, spare_idx_d;
  logic                        hit_q, hit_d;
  logic [AW-1:0]               hit_idx_q, hit_idx_d;
  entry_t                      keep_q, keep_d;
  res_t                        res_q, res_d;
  logic [ENTRIES-1:0]          written_q, written_d;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] rd_data;
  entry_t        rd_entry, view, wdata;
  logic [VA_W-1:0] va_sh;
  logic [PN_W-1:0] vpn;
  logic            view_v;
  logic [FN_W-1:0] view_f;

  // tag an entry holds until its first write
  function automatic logic [PN_W-1:0] tag_reset(input logic [AW-1:0] idx);
    logic [31:0] w;
    w = 32'(idx) << PAGE_OFFSET_BITS;
    return w[PN_W-1:0];
  endfunction

  ppt_ram #(
    .WIDTH(EW),
    .DEPTH(ENTRIES)
  ) u_ppt_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign rd_entry = rd_data;
  assign rd_addr  = iss_q[AW-1:0];
  assign wr_addr  = hit_q ? hit_idx_q : (spare_q ? spare_idx_q : LAST);

  // an entry never written reads as its reset tag with both halves invalid
  always_comb begin
    view            = rd_entry;
    view.tag        = written_q[raddr_q] ? rd_entry.tag : tag_reset(raddr_q);
    view.even_valid = written_q[raddr_q] & rd_entry.even_valid;
    view.odd_valid  = written_q[raddr_q] & rd_entry.odd_valid;
  end

  assign view_v = odd_q ? view.odd_valid : view.even_valid;
  assign view_f = odd_q ? view.odd_frame : view.even_frame;

  assign va_sh = req_i.va >> PAGE_OFFSET_BITS;
  assign vpn   = va_sh[PN_W-1:0];

  // write-back word for insert and invalidate
  always_comb begin
    wdata     = keep_q;
    wdata.tag = tag_q;
    if (kind_q == KIND_INSERT) begin
      if (odd_q) begin
        wdata.odd_frame  = frame_q;
        wdata.odd_valid  = 1'b1;
        wdata.even_valid = hit_q & keep_q.even_valid;
      end else begin
        wdata.even_frame = frame_q;
        wdata.even_valid = 1'b1;
        wdata.odd_valid  = hit_q & keep_q.odd_valid;
      end
    end else begin
      if (odd_q) begin
        wdata.odd_valid = 1'b0;
      end else begin
        wdata.even_valid = 1'b0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    tag_d       = tag_q;
    odd_d       = odd_q;
    frame_d     = frame_q;
    off_d       = off_q;
    iss_d       = iss_q;
    spare_d     = spare_q;
    spare_idx_d = spare_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    keep_d      = keep_q;
    res_d       = res_q;
    written_d   = written_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          kind_d    = req_i.kind;
          frame_d   = req_i.frame;
          off_d     = req_i.va[PAGE_OFFSET_BITS-1:0];
          iss_d     = '0;
          spare_d   = 1'b0;
          hit_d     = 1'b0;
          res_d.status = ST_OK;
          res_d.pa     = '0;
          case (req_i.kind)
            KIND_TRANSLATE: begin
              tag_d = {vpn[PN_W-1:1], 1'b0};
              odd_d = vpn[0];
              if (seg_i.done) begin
                res_d.status = seg_i.status;
                state_d      = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            KIND_INSERT, KIND_INVALIDATE: begin
              tag_d   = {req_i.page[PN_W-1:1], 1'b0};
              odd_d   = req_i.page[0];
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // reads run one entry ahead of the compare
        if (iss_q < CW'(ENTRIES)) begin
          rd_en = 1'b1;
          iss_d = iss_q + 1'b1;
        end
        if (rvalid_q) begin
          if (view.tag == tag_q) begin
            hit_d     = 1'b1;
            hit_idx_d = raddr_q;
            keep_d    = view;
            case (kind_q)
              KIND_TRANSLATE: begin
                res_d.status = view_v ? ST_OK : ST_INVALID;
                res_d.pa     = view_v ? VA_W'({view_f, off_q}) : '0;
                state_d      = S_DONE;
              end
              default: begin
                state_d = S_WRITE;
              end
            endcase
          end else begin
            if (!view.even_valid && !view.odd_valid) begin
              spare_d     = 1'b1;
              spare_idx_d = raddr_q;
            end
            if (raddr_q == LAST) begin
              case (kind_q)
                KIND_TRANSLATE: begin
                  res_d.status = ST_MISS;
                  state_d      = S_DONE;
                end
                KIND_INSERT: begin
                  state_d = S_WRITE;
                end
                default: begin
                  res_d.status = ST_NOT_FOUND;
                  state_d      = S_DONE;
                end
              endcase
            end
          end
        end
      end

      S_WRITE: begin
        wr_en              = 1'b1;
        written_d[wr_addr] = 1'b1;
        state_d            = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rvalid_d = rd_en;
  assign raddr_d  = rd_en ? rd_addr : raddr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= '0;
      tag_q       <= '0;
      odd_q       <= 1'b0;
      frame_q     <= '0;
      off_q       <= '0;
      iss_q       <= '0;
      rvalid_q    <= 1'b0;
      raddr_q     <= '0;
      spare_q     <= 1'b0;
      spare_idx_q <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      keep_q      <= '0;
      res_q       <= '0;
      written_q   <= '0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      tag_q       <= tag_d;
      odd_q       <= odd_d;
      frame_q     <= frame_d;
      off_q       <= off_d;
      iss_q       <= iss_d;
      rvalid_q    <= rvalid_d;
      raddr_q     <= raddr_d;
      spare_q     <= spare_d;
      spare_idx_q <= spare_idx_d;
      hit_q       <= hit_d;
      hit_idx_q   <= hit_idx_d;
      keep_q      <= keep_d;
      res_q       <= res_d;
      written_q   <= written_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

// ===== rtl/core/paired_page_tlb.sv =====
// paired page tlb: fully associative tlb, each entry maps an even/odd page pair
//
// input channel: in_valid_i/in_ready_o carry one beat with kind (translate,
// insert, invalidate), virtual address, privilege mode, page and frame number.
// output channel: out_valid_o/out_ready_i carry one beat per input beat with
// status and physical address. the four segment masks are written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user is to write them only while the
// block is idle, which the block itself does not enforce. one item is worked
// on at a time. translates answered by the segment masks and unknown kinds go
// to the result without a walk. other items walk the entry
// memory one entry a cycle through its single read port, stopping at the
// first tag match or after the last entry; an insert, and an invalidate that
// finds its tag, then write the entry back. the next beat is taken as soon as
// the walk sequencer is idle again. a finished result sits in the output
// register, so one new beat is accepted while the receiver stalls; a second
// result then waits in the sequencer. reset is immediate: per-entry written
// bits clear at once, masks reset to 0, and no clearing pass of the memory is
// run.
module paired_page_tlb #(
  parameter int unsigned ENTRIES          = ppt_pkg::ENTRIES_DEF,
  parameter int unsigned PAGE_OFFSET_BITS = ppt_pkg::PAGE_OFFSET_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ppt_pkg::KIND_W-1:0]   kind_i,
  input  logic [ppt_pkg::VA_W-1:0]     virtual_address_i,
  input  logic [ppt_pkg::MODE_W-1:0]   privilege_mode_i,
  input  logic [ppt_pkg::PN_W-1:0]     page_number_i,
  input  logic [ppt_pkg::FN_W-1:0]     frame_number_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ppt_pkg::ST_W-1:0]     status_o,
  output logic [ppt_pkg::VA_W-1:0]     physical_address_o,
  input  logic                         cfg_we_i,
  input  logic [ppt_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [ppt_pkg::CFG_W-1:0]    cfg_data_i
);
  import ppt_pkg::*;

  cfg_t cfg_q;
  seg_t seg;
  req_t req;
  res_t res;
  logic res_valid, res_ready;
  logic            out_valid_q;
  logic [ST_W-1:0] status_q;
  logic [VA_W-1:0] pa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KERNEL_MAPPED:     cfg_q.k_map_mask      <= cfg_data_i;
        CFG_SUPERVISOR_MAPPED: cfg_q.s_map_mask      <= cfg_data_i;
        CFG_KERNEL_UNCACHED:   cfg_q.k_uncached_mask <= cfg_data_i;
        CFG_KERNEL_UNMAPPED:   cfg_q.k_cached_mask   <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  ppt_seg u_ppt_seg (
    .va_i  (virtual_address_i),
    .mode_i(privilege_mode_i),
    .cfg_i (cfg_q),
    .seg_o (seg)
  );

  assign req.kind  = kind_i;
  assign req.va    = virtual_address_i;
  assign req.page  = page_number_i;
  assign req.frame = frame_number_i;

  ppt_engine #(
    .ENTRIES         (ENTRIES),
    .PAGE_OFFSET_BITS(PAGE_OFFSET_BITS)
  ) u_ppt_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_ready_o(in_ready_o),
    .req_i      (req),
    .seg_i      (seg),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output register parts the sequencer from the receiver
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      status_q <= res.status;
      pa_q     <= res.pa;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign physical_address_o = pa_q;

endmodule

// ===== rtl/core/ppt_checker.sv =====
// port level checks of the paired page tlb and their bind
module ppt_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [ppt_pkg::ST_W-1:0] status_o,
  input logic [ppt_pkg::VA_W-1:0] physical_address_o
);
  import ppt_pkg::*;

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(physical_address_o))
    else $error("stalled output beat changed");

  // only a good translate carries an address
  a_pa_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> physical_address_o == '0)
    else $error("address given with error status");

  // one item in the sequencer at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while busy");

endmodule

bind paired_page_tlb ppt_checker u_ppt_checker (.*);
